>>> rtl/ycc_pkg.sv
// ycc_pkg: shared constants and helpers for the ycbcr/rgb colour converter
// holds coefficient values in millionths and the fixed-point quantiser
// no dependencies
package ycc_pkg;

   // default number of fractional coefficient bits
   localparam int COEFF_FRAC_BITS_DEF = 16;

   // component and stream widths
   localparam int COMP_W  = 8;
   localparam int WORD_W  = 3 * COMP_W;

   // direction register codes
   localparam logic DIR_YCC_TO_RGB = 1'b0;
   localparam logic DIR_RGB_TO_YCC = 1'b1;

   // jfif coefficients in millionths
   localparam longint C_CR_R  = 64'd1402000;
   localparam longint C_CB_G  = 64'd344136;
   localparam longint C_CR_G  = 64'd714136;
   localparam longint C_CB_B  = 64'd1772000;
   localparam longint C_R_Y   = 64'd299000;
   localparam longint C_G_Y   = 64'd587000;
   localparam longint C_B_Y   = 64'd114000;
   localparam longint C_R_CB  = 64'd168736;
   localparam longint C_G_CB  = 64'd331264;
   localparam longint C_G_CR  = 64'd418688;
   localparam longint C_B_CR  = 64'd81312;
   localparam longint C_ONE   = 64'd1000000;
   localparam longint C_HALF  = 64'd500000;
   localparam longint CHROMA_OFS = 64'd128;

   // round(micro / 1e6 * 2^frac), ties upwards; elaboration time only
   function automatic longint cq(input longint micro, input int frac);
      return ((micro << frac) + 64'd500000) / 64'd1000000;
   endfunction

endpackage

>>> rtl/ycc_mult_stage.sv
// ycc_mult_stage: first pipeline stage, chroma offset and nine coefficient products
// uses ycc_pkg for coefficients and direction codes
// feeds ycc_sum_stage
module ycc_mult_stage #(
   parameter int COEFF_FRAC_BITS = ycc_pkg::COEFF_FRAC_BITS_DEF,
   localparam int KW = COEFF_FRAC_BITS + 2,
   localparam int PW = COEFF_FRAC_BITS + 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     dir,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [ycc_pkg::COMP_W-1:0] in_comp0,
   input  logic [ycc_pkg::COMP_W-1:0] in_comp1,
   input  logic [ycc_pkg::COMP_W-1:0] in_comp2,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic                     out_dir,
   output logic [2:0][2:0][PW-1:0]  out_prod
);

   localparam int F = COEFF_FRAC_BITS;

   // coefficient rows per output, columns per input component
   localparam logic signed [KW-1:0] K_FWD [3][3] = '{
      '{KW'(ycc_pkg::cq(ycc_pkg::C_ONE, F)), KW'(0),
        KW'(ycc_pkg::cq(ycc_pkg::C_CR_R, F))},
      '{KW'(ycc_pkg::cq(ycc_pkg::C_ONE, F)), KW'(-ycc_pkg::cq(ycc_pkg::C_CB_G, F)),
        KW'(-ycc_pkg::cq(ycc_pkg::C_CR_G, F))},
      '{KW'(ycc_pkg::cq(ycc_pkg::C_ONE, F)), KW'(ycc_pkg::cq(ycc_pkg::C_CB_B, F)),
        KW'(0)}
   };
   localparam logic signed [KW-1:0] K_REV [3][3] = '{
      '{KW'(ycc_pkg::cq(ycc_pkg::C_R_Y, F)), KW'(ycc_pkg::cq(ycc_pkg::C_G_Y, F)),
        KW'(ycc_pkg::cq(ycc_pkg::C_B_Y, F))},
      '{KW'(-ycc_pkg::cq(ycc_pkg::C_R_CB, F)), KW'(-ycc_pkg::cq(ycc_pkg::C_G_CB, F)),
        KW'(ycc_pkg::cq(ycc_pkg::C_HALF, F))},
      '{KW'(ycc_pkg::cq(ycc_pkg::C_HALF, F)), KW'(-ycc_pkg::cq(ycc_pkg::C_G_CR, F)),
        KW'(-ycc_pkg::cq(ycc_pkg::C_B_CR, F))}
   };

   logic                    valid_ff, valid_in;
   logic                    dir_ff;
   logic [2:0][2:0][PW-1:0] prod_ff, prod_in;
   logic signed [8:0]       opnd [3];
   logic                    advance;

   // stage moves when empty or when downstream takes its word
   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // operands: luma straight, chroma centred on zero in forward direction
   always_comb begin
      opnd[0] = {1'b0, in_comp0};
      if (dir == ycc_pkg::DIR_YCC_TO_RGB) begin
         opnd[1] = {~in_comp1[7], ~in_comp1[7], in_comp1[6:0]};
         opnd[2] = {~in_comp2[7], ~in_comp2[7], in_comp2[6:0]};
      end else begin
         opnd[1] = {1'b0, in_comp1};
         opnd[2] = {1'b0, in_comp2};
      end
   end

   // nine constant-coefficient products
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         for (int k = 0; k < 3; k++) begin
            if (dir == ycc_pkg::DIR_YCC_TO_RGB) begin
               prod_in[j][k] = PW'(K_FWD[j][k]) * PW'(opnd[k]);
            end else begin
               prod_in[j][k] = PW'(K_REV[j][k]) * PW'(opnd[k]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         prod_ff <= prod_in;
         dir_ff  <= dir;
      end
   end

   assign out_valid = valid_ff;
   assign out_dir   = dir_ff;
   assign out_prod  = prod_ff;

endmodule

>>> rtl/ycc_sum_stage.sv
// ycc_sum_stage: second pipeline stage, sums products with offset and rounding half
// uses ycc_pkg for direction codes and the chroma offset
// fed by ycc_mult_stage, feeds ycc_round_stage
module ycc_sum_stage #(
   parameter int COEFF_FRAC_BITS = ycc_pkg::COEFF_FRAC_BITS_DEF,
   localparam int PW = COEFF_FRAC_BITS + 11,
   localparam int SW = COEFF_FRAC_BITS + 13
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic                    in_dir,
   input  logic [2:0][2:0][PW-1:0] in_prod,
   output logic                    out_valid,
   input  logic                    out_ready,
   output logic [2:0][SW-1:0]      out_sum
);

   localparam logic signed [SW-1:0] HALF_FX = SW'(64'd1 << (COEFF_FRAC_BITS - 1));
   localparam logic signed [SW-1:0] OFS_FX  =
      SW'(ycc_pkg::CHROMA_OFS << COEFF_FRAC_BITS);

   logic               valid_ff, valid_in;
   logic [2:0][SW-1:0] sum_ff, sum_in;
   logic               advance;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // per output: three products, chroma offset in reverse direction, half for rounding
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sum_in[j] = SW'($signed(in_prod[j][0])) + SW'($signed(in_prod[j][1]))
                   + SW'($signed(in_prod[j][2])) + HALF_FX;
         if (in_dir == ycc_pkg::DIR_RGB_TO_YCC && j != 0) begin
            sum_in[j] = sum_in[j] + OFS_FX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         sum_ff <= sum_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_sum   = sum_ff;

endmodule

>>> rtl/ycc_round_stage.sv
// ycc_round_stage: last pipeline stage, drops fraction and clamps to 0..255
// uses ycc_pkg for the component width
// fed by ycc_sum_stage, its register is the output word
module ycc_round_stage #(
   parameter int COEFF_FRAC_BITS = ycc_pkg::COEFF_FRAC_BITS_DEF,
   localparam int SW = COEFF_FRAC_BITS + 13
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  logic [2:0][SW-1:0]                 in_sum,
   output logic                               out_valid,
   input  logic                               out_ready,
   output logic [2:0][ycc_pkg::COMP_W-1:0]    out_comp
);

   localparam int QW = SW - COEFF_FRAC_BITS;
   localparam int CW = ycc_pkg::COMP_W;

   logic                  valid_ff, valid_in;
   logic [2:0][CW-1:0]    comp_ff, comp_in;
   logic [2:0][QW-1:0]    whole;
   logic                  advance;

   assign advance  = !valid_ff || out_ready;
   assign in_ready = advance;
   assign valid_in = advance ? in_valid : valid_ff;

   // negative goes to zero, anything past 255 saturates
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         whole[j] = in_sum[j][SW-1:COEFF_FRAC_BITS];
         if (whole[j][QW-1]) begin
            comp_in[j] = '0;
         end else if (|whole[j][QW-2:CW]) begin
            comp_in[j] = '1;
         end else begin
            comp_in[j] = whole[j][CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         comp_ff <= comp_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_comp  = comp_ff;

endmodule

>>> rtl/ycbcr_rgb_color_convert_unit.sv
// Converts full-range 8-bit pixels between YCbCr and RGB with JFIF coefficients.
// Input words arrive on the req_ stream channel, results leave on rsp_; csr_ sets
// the direction (0: YCbCr to RGB, 1: RGB to YCbCr); the user must write it while idle,
// as the block itself does not enforce this. Each word carries three components,
// component 0 in the low byte. Pipeline: product stage, sum stage, round/clamp stage
// whose register drives rsp_. One word per cycle is taken and delivered when the
// receiver keeps up.
// Every stage advances when it is empty or the next one takes its word, so bubbles
// close up and new words are still accepted while a result waits on rsp_.
// When the receiver stalls, the pipe fills and req_tready drops after the
// stages hold a word each; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets direction to YCbCr to RGB.
// Depends on ycc_pkg and the three ycc_*_stage modules.
module ycbcr_rgb_color_convert_unit #(
   parameter int COEFF_FRAC_BITS = ycc_pkg::COEFF_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // configuration
   input  logic                        csr_wr_en,
   input  logic                        csr_wr_data,    // direction
   // input words
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [ycc_pkg::WORD_W-1:0]  req_tdata,      // in_comp0, in_comp1, in_comp2
   // result words
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [ycc_pkg::WORD_W-1:0]  rsp_tdata       // out_comp0, out_comp1, out_comp2
);

   localparam int PW = COEFF_FRAC_BITS + 11;
   localparam int SW = COEFF_FRAC_BITS + 13;
   localparam int CW = ycc_pkg::COMP_W;

   logic                    dir_ff, dir_in;
   logic                    m_valid, m_ready, m_dir;
   logic [2:0][2:0][PW-1:0] m_prod;
   logic                    s_valid, s_ready;
   logic [2:0][SW-1:0]      s_sum;
   logic [2:0][CW-1:0]      r_comp;

   // direction register
   assign dir_in = csr_wr_en ? csr_wr_data : dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff <= ycc_pkg::DIR_YCC_TO_RGB;
      end else begin
         dir_ff <= dir_in;
      end
   end

   // product stage
   ycc_mult_stage #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_mult (
      .clock     (clock),
      .reset     (reset),
      .dir       (dir_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_comp0  (req_tdata[CW-1:0]),
      .in_comp1  (req_tdata[2*CW-1:CW]),
      .in_comp2  (req_tdata[3*CW-1:2*CW]),
      .out_valid (m_valid),
      .out_ready (m_ready),
      .out_dir   (m_dir),
      .out_prod  (m_prod)
   );

   // sum stage
   ycc_sum_stage #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m_valid),
      .in_ready  (m_ready),
      .in_dir    (m_dir),
      .in_prod   (m_prod),
      .out_valid (s_valid),
      .out_ready (s_ready),
      .out_sum   (s_sum)
   );

   // round and clamp stage, drives the result channel
   ycc_round_stage #(.COEFF_FRAC_BITS(COEFF_FRAC_BITS)) u_round (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s_valid),
      .in_ready  (s_ready),
      .in_sum    (s_sum),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_comp  (r_comp)
   );

   assign rsp_tdata = {r_comp[2], r_comp[1], r_comp[0]};

endmodule

>>> rtl/ycc_checker.sv
// ycc_checker: port-level checks on the colour converter's handshakes and latency
// uses ycc_pkg for the word width; bound to ycbcr_rgb_color_convert_unit below
module ycc_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [ycc_pkg::WORD_W-1:0] rsp_tdata
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // an empty output register never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");

   // with the receiver taking words, an accepted word passes the product, sum and round registers to rsp_tvalid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) ##1 rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result missing three cycles after acceptance");

endmodule

bind ycbcr_rgb_color_convert_unit ycc_checker u_ycc_checker (
   .clock       (clock),
   .reset       (reset),
   .req_tvalid  (req_tvalid),
   .req_tready  (req_tready),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata)
);
